// ===== rtl/core/grd_pkg.sv =====
// Shared types, constants and the arctangent table of the route distance recorder.
`default_nettype none
package grd_pkg;

	localparam int ROUTE_DEPTH  = 512;
	localparam int CORDIC_STEPS = 24;
	localparam int ADDR_W       = $clog2(ROUTE_DEPTH);
	localparam int CNT_W        = $clog2(ROUTE_DEPTH + 1);
	localparam int XY_W         = 36;
	localparam int Z_W          = 38;
	localparam int MUL_W        = 34;
	localparam int PROD_W       = 2 * MUL_W;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_STOP   = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam logic [2:0] MUL_ANG = 3'd0;
	localparam logic [2:0] MUL_CC  = 3'd1;
	localparam logic [2:0] MUL_U   = 3'd2;
	localparam logic [2:0] MUL_SS  = 3'd3;
	localparam logic [2:0] MUL_US  = 3'd4;
	localparam logic [2:0] MUL_D   = 3'd5;

	localparam logic [1:0] ANG_DLAT = 2'd0;
	localparam logic [1:0] ANG_DLON = 2'd1;
	localparam logic [1:0] ANG_LAT1 = 2'd2;
	localparam logic [1:0] ANG_LAT2 = 2'd3;

	localparam logic REG_INTERVAL = 1'b0;

	localparam logic signed [Z_W-1:0]   PI_Q32      = Z_W'(64'sd13493037705);
	localparam logic signed [Z_W-1:0]   HALF_PI_Q32 = Z_W'(64'sd6746518852);
	localparam logic signed [Z_W-1:0]   TWO_PI_Q32  = Z_W'(64'sd26986075410);
	localparam logic signed [XY_W-1:0]  GAIN_Q30    = XY_W'(64'sd652032874);
	localparam logic signed [MUL_W-1:0] DEG_K       = MUL_W'(64'sd2012227627);
	localparam logic signed [MUL_W-1:0] DIST_K      = MUL_W'(64'sd203872000);
	localparam logic [60:0]             ONE_Q60     = 61'(64'd1 << 60);

	function automatic longint div_pos(longint num, longint den);
		longint quo;
		longint rmd;
		int b;
		quo = 0;
		rmd = 0;
		for (b = 62; b >= 0; b--) begin
			rmd = (rmd << 1) | ((num >>> b) & longint'(1));
			if (rmd >= den) begin
				rmd = rmd - den;
				quo = quo | (longint'(1) << b);
			end
		end
		return quo;
	endfunction

	function automatic logic [32*Z_W-1:0] build_atan();
		logic [32*Z_W-1:0] tab;
		longint sum;
		longint term;
		int i;
		int k;
		int e;
		tab = '0;
		tab[Z_W-1:0] = Z_W'(64'd3373259426);
		for (i = 1; i < 32; i++) begin
			sum = 0;
			for (k = 0; k < 32; k++) begin
				e = i * (2 * k + 1);
				if (e <= 62) begin
					term = div_pos(longint'(1) << (62 - e), longint'(2 * k + 1));
					sum = ((k & 1) != 0) ? sum - term : sum + term;
				end
			end
			tab[i*Z_W +: Z_W] = Z_W'((sum + (longint'(1) << 29)) >>> 30);
		end
		return tab;
	endfunction

	localparam logic [32*Z_W-1:0] ATAN_TAB = build_atan();

	typedef struct packed {
		logic signed [17:0] alt;
		logic [15:0]        spd;
		logic signed [31:0] lon;
		logic signed [30:0] lat;
	} point_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic               fix;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic [15:0]        spd;
		logic signed [17:0] alt;
		logic [31:0]        now;
		logic [8:0]         idx;
	} item_t;

	typedef struct packed {
		logic               recording;
		logic [9:0]         point_count;
		logic [31:0]        route_distance;
		logic               point_stored;
		logic               point_dropped;
		logic signed [30:0] read_latitude;
		logic signed [31:0] read_longitude;
		logic [15:0]        read_speed;
		logic signed [17:0] read_altitude;
	} res_t;

	typedef struct packed {
		logic       cap;
		logic       rd_prev;
		logic       rd_idx;
		logic       mul_en;
		logic [2:0] mul_op;
		logic [1:0] ang_sel;
		logic       rot_go;
		logic       rot_take;
		logic       u_save;
		logic       t1_save;
		logic       a_save;
		logic       sq_go;
		logic       vec_go;
		logic       d_round;
		logic       d_add;
		logic       do_store;
		logic       do_drop;
		logic       do_start;
		logic       do_stop;
		logic       out_load;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       due;
		logic       full;
		logic       has_prev;
		logic       read_ok;
		logic       same_pt;
		logic       cordic_done;
		logic       sq_done;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/grd_store.sv =====
// Point store: one write port and one registered read port.
`default_nettype none
module grd_store import grd_pkg::*; (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output point_t            rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  point_t            wr_data
);

	point_t mem [ROUTE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/grd_cordic.sv =====
// Iterative CORDIC unit for sine and cosine (rotation) and arctangent (vectoring).
`default_nettype none
module grd_cordic import grd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   vec_mode,
	input  logic signed [Z_W-1:0]  z_in,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	output logic                   done,
	output logic signed [XY_W-1:0] sin_out,
	output logic signed [XY_W-1:0] cos_out,
	output logic signed [Z_W-1:0]  z_out
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_REDUCE = 2'd1;
	localparam logic [1:0] PH_FOLD   = 2'd2;
	localparam logic [1:0] PH_ITER   = 2'd3;
	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

	logic [1:0]            phase_q;
	logic [4:0]            cnt_q;
	logic                  done_q;
	logic                  mode_q;
	logic                  neg_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0]  at;
	logic                   dir;

	assign dx  = y_q >>> cnt_q;
	assign dy  = x_q >>> cnt_q;
	assign at  = signed'(ATAN_TAB[cnt_q*Z_W +: Z_W]);
	assign dir = mode_q ? ~y_q[XY_W-1] : ~z_q[Z_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= vec_mode ? PH_ITER : PH_REDUCE;
					end
				end
				PH_REDUCE: phase_q <= PH_FOLD;
				PH_FOLD:   phase_q <= PH_ITER;
				PH_ITER: begin
					if (cnt_q == LAST_STEP) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				if (start) begin
					mode_q <= vec_mode;
					neg_q  <= 1'b0;
					cnt_q  <= '0;
					if (vec_mode) begin
						x_q <= x_in;
						y_q <= y_in;
						z_q <= '0;
					end else begin
						x_q <= GAIN_Q30;
						y_q <= '0;
						z_q <= z_in;
					end
				end
			end
			PH_REDUCE: begin
				if (z_q > PI_Q32) begin
					z_q <= z_q - TWO_PI_Q32;
				end else if (z_q < -PI_Q32) begin
					z_q <= z_q + TWO_PI_Q32;
				end
			end
			PH_FOLD: begin
				if (z_q > HALF_PI_Q32) begin
					z_q   <= PI_Q32 - z_q;
					neg_q <= 1'b1;
				end else if (z_q < -HALF_PI_Q32) begin
					z_q   <= -PI_Q32 - z_q;
					neg_q <= 1'b1;
				end
			end
			PH_ITER: begin
				cnt_q <= cnt_q + 5'd1;
				if (mode_q) begin
					x_q <= dir ? x_q + dx : x_q - dx;
					y_q <= dir ? y_q - dy : y_q + dy;
					z_q <= dir ? z_q + at : z_q - at;
				end else begin
					x_q <= dir ? x_q - dx : x_q + dx;
					y_q <= dir ? y_q + dy : y_q - dy;
					z_q <= dir ? z_q - at : z_q + at;
				end
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign sin_out = y_q;
	assign cos_out = neg_q ? -x_q : x_q;
	assign z_out   = z_q;

endmodule
`default_nettype wire

// ===== rtl/core/grd_isqrt.sv =====
// Bit-serial integer square root: each step brings down two operand bits and settles one result bit.
`default_nettype none
module grd_isqrt import grd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [60:0] v_in,
	output logic        done,
	output logic [30:0] root
);

	localparam logic [4:0] LAST_STEP = 5'd31;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [62:0] v_q;
	logic [62:0] r_q;
	logic [62:0] bit_q;
	logic [62:0] sum;
	logic        ge;

	assign sum = r_q + bit_q;
	assign ge  = v_q >= sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= 63'(v_in);
			r_q   <= '0;
			bit_q <= 63'(1) << 62;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				v_q <= v_q - sum;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
			cnt_q <= cnt_q + 5'd1;
		end
	end

	assign done = done_q;
	assign root = r_q[30:0];

endmodule
`default_nettype wire

// ===== rtl/core/grd_datapath.sv =====
// Datapath: route state, point store, shared multiplier, CORDIC, square roots and result register.
`default_nettype none
module grd_datapath import grd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic [15:0] interval,
	input  ctl_t        ctl,
	input  logic        m_tready,
	output sts_t        sts,
	output logic        m_tvalid,
	output res_t        res
);

	item_t                  cur_q;
	logic                   rec_q;
	logic [CNT_W-1:0]       count_q;
	logic [31:0]            dist_q;
	logic [31:0]            last_q;
	logic                   stored_q;
	logic                   dropped_q;
	logic                   rdsel_q;
	logic                   out_valid_q;
	res_t                   res_q;

	logic signed [XY_W-1:0] sl_q;
	logic signed [XY_W-1:0] so_q;
	logic signed [XY_W-1:0] c1_q;
	logic signed [XY_W-1:0] c2_q;
	logic signed [MUL_W-1:0] u_q;
	logic signed [PROD_W-1:0] t1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                   sign_q;
	logic [60:0]            a_q;
	logic [31:0]            d_q;

	point_t                 rd_data;
	point_t                 wr_data;
	logic [ADDR_W-1:0]      rd_addr;

	logic signed [32:0]     dlat;
	logic signed [32:0]     dlon;
	logic signed [32:0]     ang_v;
	logic                   ang_neg;
	logic [32:0]            ang_mag;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] zsh;
	logic signed [Z_W-1:0]  zmag;
	logic signed [Z_W-1:0]  rot_z;
	logic signed [62:0]     asum;
	logic [32:0]            dsum;
	logic signed [MUL_W-1:0] zclamp;

	logic                   cordic_done;
	logic signed [XY_W-1:0] cor_sin;
	logic signed [XY_W-1:0] cor_cos;
	logic signed [Z_W-1:0]  cor_z;
	logic                   sq_done;
	logic                   sq2_done;
	logic [30:0]            s_root;
	logic [30:0]            c_root;

	assign rd_addr = ctl.rd_prev ? ADDR_W'(count_q - 1'b1) : ADDR_W'(cur_q.idx);
	assign wr_data = '{alt: cur_q.alt, spd: cur_q.spd, lon: cur_q.lon, lat: cur_q.lat};

	grd_store u_store (
		.clk     (clk),
		.rd_en   (ctl.rd_prev | ctl.rd_idx),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (ctl.do_store),
		.wr_addr (ADDR_W'(count_q)),
		.wr_data (wr_data)
	);

	assign dlat = 33'(cur_q.lat) - 33'(rd_data.lat);
	assign dlon = 33'(cur_q.lon) - 33'(rd_data.lon);

	always_comb begin
		unique case (ctl.ang_sel)
			ANG_DLAT: ang_v = dlat;
			ANG_DLON: ang_v = dlon;
			ANG_LAT1: ang_v = 33'(rd_data.lat);
			ANG_LAT2: ang_v = 33'(cur_q.lat);
			default:  ang_v = '0;
		endcase
	end

	assign ang_neg = ang_v[32];
	assign ang_mag = ang_neg ? unsigned'(-ang_v) : unsigned'(ang_v);
	assign zclamp  = cor_z[Z_W-1] ? '0 : MUL_W'(cor_z);

	always_comb begin
		unique case (ctl.mul_op)
			MUL_ANG: begin
				mul_a = signed'({1'b0, ang_mag});
				mul_b = DEG_K;
			end
			MUL_CC: begin
				mul_a = MUL_W'(c1_q);
				mul_b = MUL_W'(c2_q);
			end
			MUL_U: begin
				mul_a = MUL_W'(so_q);
				mul_b = MUL_W'(prod_q >>> 30);
			end
			MUL_SS: begin
				mul_a = MUL_W'(sl_q);
				mul_b = MUL_W'(sl_q);
			end
			MUL_US: begin
				mul_a = u_q;
				mul_b = MUL_W'(so_q);
			end
			MUL_D: begin
				mul_a = zclamp;
				mul_b = DIST_K;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	assign zsh   = (ctl.ang_sel == ANG_DLAT || ctl.ang_sel == ANG_DLON) ?
		(prod_q >>> 29) : (prod_q >>> 28);
	assign zmag  = Z_W'(zsh);
	assign rot_z = sign_q ? -zmag : zmag;
	assign asum  = 63'(t1_q) + 63'(prod_q);
	assign dsum  = {1'b0, dist_q} + {1'b0, d_q};

	grd_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.rot_go | ctl.vec_go),
		.vec_mode (ctl.vec_go),
		.z_in     (rot_z),
		.x_in     (signed'(XY_W'(c_root))),
		.y_in     (signed'(XY_W'(s_root))),
		.done     (cordic_done),
		.sin_out  (cor_sin),
		.cos_out  (cor_cos),
		.z_out    (cor_z)
	);

	grd_isqrt u_sqrt_s (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.sq_go),
		.v_in   (a_q),
		.done   (sq_done),
		.root   (s_root)
	);

	grd_isqrt u_sqrt_c (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.sq_go),
		.v_in   (ONE_Q60 - a_q),
		.done   (sq2_done),
		.root   (c_root)
	);

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cur_q <= item;
		end
		if (ctl.mul_en) begin
			prod_q <= prod_c;
			if (ctl.mul_op == MUL_ANG) begin
				sign_q <= ang_neg;
			end
		end
		if (ctl.rot_take) begin
			unique case (ctl.ang_sel)
				ANG_DLAT: sl_q <= cor_sin;
				ANG_DLON: so_q <= cor_sin;
				ANG_LAT1: c1_q <= cor_cos;
				ANG_LAT2: c2_q <= cor_cos;
				default: ;
			endcase
		end
		if (ctl.u_save) begin
			u_q <= MUL_W'(prod_q >>> 30);
		end
		if (ctl.t1_save) begin
			t1_q <= prod_q;
		end
		if (ctl.a_save) begin
			if (asum < 0) begin
				a_q <= '0;
			end else if (asum > 63'(ONE_Q60)) begin
				a_q <= ONE_Q60;
			end else begin
				a_q <= 61'(asum);
			end
		end
		if (ctl.d_round) begin
			d_q <= 32'((prod_q[63:0] + 64'h8000_0000) >> 32);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q       <= 1'b0;
			count_q     <= '0;
			dist_q      <= '0;
			last_q      <= '0;
			stored_q    <= 1'b0;
			dropped_q   <= 1'b0;
			rdsel_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.cap) begin
				stored_q  <= 1'b0;
				dropped_q <= 1'b0;
				rdsel_q   <= 1'b0;
			end
			if (ctl.rd_idx) begin
				rdsel_q <= 1'b1;
			end
			if (ctl.do_start) begin
				rec_q   <= 1'b1;
				count_q <= '0;
				dist_q  <= '0;
				last_q  <= '0;
			end
			if (ctl.do_stop) begin
				rec_q <= 1'b0;
			end
			if (ctl.do_drop) begin
				last_q    <= cur_q.now;
				dropped_q <= 1'b1;
			end
			if (ctl.do_store) begin
				last_q   <= cur_q.now;
				count_q  <= count_q + 1'b1;
				stored_q <= 1'b1;
			end
			if (ctl.d_add) begin
				dist_q <= dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res_q.recording      <= rec_q;
			res_q.point_count    <= 10'(count_q);
			res_q.route_distance <= dist_q;
			res_q.point_stored   <= stored_q;
			res_q.point_dropped  <= dropped_q;
			res_q.read_latitude  <= rdsel_q ? rd_data.lat : '0;
			res_q.read_longitude <= rdsel_q ? rd_data.lon : '0;
			res_q.read_speed     <= rdsel_q ? rd_data.spd : '0;
			res_q.read_altitude  <= rdsel_q ? rd_data.alt : '0;
		end
	end

	assign sts.cmd         = cur_q.cmd;
	assign sts.due         = rec_q && cur_q.fix &&
		((cur_q.now - last_q) >= {16'b0, interval});
	assign sts.full        = count_q >= CNT_W'(ROUTE_DEPTH);
	assign sts.has_prev    = count_q != '0;
	assign sts.read_ok     = (cur_q.idx < count_q) && ({23'b0, cur_q.idx} < 32'(ROUTE_DEPTH));
	assign sts.same_pt     = (rd_data.lat == cur_q.lat) && (rd_data.lon == cur_q.lon);
	assign sts.cordic_done = cordic_done;
	assign sts.sq_done     = sq_done & sq2_done;
	assign sts.out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign res      = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/grd_ctrl.sv =====
// Controller: sequences each request through the datapath.
`default_nettype none
module grd_ctrl import grd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_DECODE   = 5'd1;
	localparam logic [4:0] ST_PREV     = 5'd2;
	localparam logic [4:0] ST_ANG_MUL  = 5'd3;
	localparam logic [4:0] ST_ROT_GO   = 5'd4;
	localparam logic [4:0] ST_ROT_WAIT = 5'd5;
	localparam logic [4:0] ST_M_CC     = 5'd6;
	localparam logic [4:0] ST_M_U      = 5'd7;
	localparam logic [4:0] ST_M_SS     = 5'd8;
	localparam logic [4:0] ST_M_US     = 5'd9;
	localparam logic [4:0] ST_M_A      = 5'd10;
	localparam logic [4:0] ST_SQ_GO    = 5'd11;
	localparam logic [4:0] ST_SQ_WAIT  = 5'd12;
	localparam logic [4:0] ST_VEC_GO   = 5'd13;
	localparam logic [4:0] ST_VEC_WAIT = 5'd14;
	localparam logic [4:0] ST_D_MUL    = 5'd15;
	localparam logic [4:0] ST_D_RND    = 5'd16;
	localparam logic [4:0] ST_D_ADD    = 5'd17;
	localparam logic [4:0] ST_OUT      = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [1:0] ang_q;
	logic       ang_clr;
	logic       ang_inc;

	always_comb begin
		ctl         = '0;
		ctl.ang_sel = ang_q;
		state_d     = state_q;
		ang_clr     = 1'b0;
		ang_inc     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.cap = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_OUT;
				unique case (sts.cmd)
					CMD_START: ctl.do_start = 1'b1;
					CMD_STOP:  ctl.do_stop  = 1'b1;
					CMD_READ:  ctl.rd_idx   = sts.read_ok;
					CMD_SAMPLE: begin
						if (sts.due) begin
							if (sts.full) begin
								ctl.do_drop = 1'b1;
							end else if (!sts.has_prev) begin
								ctl.do_store = 1'b1;
							end else begin
								ctl.rd_prev = 1'b1;
								state_d     = ST_PREV;
							end
						end
					end
					default: ;
				endcase
			end
			ST_PREV: begin
				if (sts.same_pt) begin
					ctl.do_store = 1'b1;
					state_d      = ST_OUT;
				end else begin
					ang_clr = 1'b1;
					state_d = ST_ANG_MUL;
				end
			end
			ST_ANG_MUL: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_ANG;
				state_d    = ST_ROT_GO;
			end
			ST_ROT_GO: begin
				ctl.rot_go = 1'b1;
				state_d    = ST_ROT_WAIT;
			end
			ST_ROT_WAIT: begin
				if (sts.cordic_done) begin
					ctl.rot_take = 1'b1;
					if (ang_q == ANG_LAT2) begin
						state_d = ST_M_CC;
					end else begin
						ang_inc = 1'b1;
						state_d = ST_ANG_MUL;
					end
				end
			end
			ST_M_CC: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_CC;
				state_d    = ST_M_U;
			end
			ST_M_U: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_U;
				state_d    = ST_M_SS;
			end
			ST_M_SS: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_SS;
				ctl.u_save = 1'b1;
				state_d    = ST_M_US;
			end
			ST_M_US: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_op  = MUL_US;
				ctl.t1_save = 1'b1;
				state_d     = ST_M_A;
			end
			ST_M_A: begin
				ctl.a_save = 1'b1;
				state_d    = ST_SQ_GO;
			end
			ST_SQ_GO: begin
				ctl.sq_go = 1'b1;
				state_d   = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (sts.sq_done) begin
					state_d = ST_VEC_GO;
				end
			end
			ST_VEC_GO: begin
				ctl.vec_go = 1'b1;
				state_d    = ST_VEC_WAIT;
			end
			ST_VEC_WAIT: begin
				if (sts.cordic_done) begin
					state_d = ST_D_MUL;
				end
			end
			ST_D_MUL: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_D;
				state_d    = ST_D_RND;
			end
			ST_D_RND: begin
				ctl.d_round = 1'b1;
				state_d     = ST_D_ADD;
			end
			ST_D_ADD: begin
				ctl.d_add    = 1'b1;
				ctl.do_store = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ang_q   <= ANG_DLAT;
		end else begin
			state_q <= state_d;
			if (ang_clr) begin
				ang_q <= ANG_DLAT;
			end else if (ang_inc) begin
				ang_q <= ang_q + 2'd1;
			end
		end
	end

	assign s_tready = state_q == ST_IDLE;

endmodule
`default_nettype wire

// ===== rtl/core/gps_route_distance_recorder.sv =====
// Top level of the route distance recorder: stream ports, configuration port and core.
//
// Each request on the slave stream carries a command (sample, start, stop or read)
// and one fix. The block answers every request with exactly one result on the
// master stream: recording flag, point count, total distance, stored and dropped
// flags, and the point fields for a read.
// Start, stop, reads, samples that are not due, dropped samples and the first
// point of a route go from capture through decode straight to the output state;
// a sample at the same spot as the previous point is stored after a compare. A due
// sample that follows a different point computes the haversine distance with
// one shared CORDIC unit (four rotations and one vectoring pass of 24 iterations
// each) and two parallel 32-step square roots, then adds it to the route distance.
// One request is processed at a time; s_tready is high while the block is idle.
// A finished result waits in an output register while the next request is
// accepted; if the receiver stalls, processing holds before overwriting it.
// The APB port holds the sample interval in milliseconds at address 0.
// Reset clears the route, recording, distance and last sample time and sets the
// interval to 1000 ms; the point store itself is not cleared.
`default_nettype none
module gps_route_distance_recorder import grd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// latitude, longitude, ground_speed, altitude, now_ms, read_index
	input  logic [143:0] s_tdata,
	// command, fix_valid
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// recording, point_count, route_distance, point_stored, point_dropped,
	// read_latitude, read_longitude, read_speed, read_altitude
	output logic [143:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [15:0] interval_q;
	item_t       item;
	res_t        res;
	ctl_t        ctl;
	sts_t        sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_INTERVAL) ? {16'b0, interval_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 16'd1000;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_INTERVAL) begin
			interval_q <= pwdata[15:0];
		end
	end

	assign item.cmd = s_tuser[1:0];
	assign item.fix = s_tuser[2];
	assign item.lat = s_tdata[30:0];
	assign item.lon = s_tdata[62:31];
	assign item.spd = s_tdata[78:63];
	assign item.alt = s_tdata[96:79];
	assign item.now = s_tdata[128:97];
	assign item.idx = s_tdata[137:129];

	grd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	grd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.interval (interval_q),
		.ctl      (ctl),
		.m_tready (m_tready),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.res      (res)
	);

	assign m_tdata = {2'b0, res.read_altitude, res.read_speed, res.read_longitude,
		res.read_latitude, res.point_dropped, res.point_stored, res.route_distance,
		res.point_count, res.recording};

endmodule
`default_nettype wire
